// ===== rtl/lfp_pkg.sv =====
// ----------------------------------------------------------------------------
// lfp_pkg
// Shared types and constants for the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lfp_pkg;

  localparam int MAX_PAYLOAD_DEF = 4096;
  localparam int HDR_BYTES       = 12;
  localparam int HDR_FRONT_BYTES = 8;
  localparam int MAXLEN_W        = 13;
  localparam int ADDR_W          = 4;
  localparam int DATA_W          = 32;

  localparam logic [31:0]         MAGIC_RST   = 32'h5350_4152;
  localparam logic [15:0]         VERSION_RST = 16'd2;
  localparam logic [15:0]         RESP_RST    = 16'h8000;
  localparam logic [MAXLEN_W-1:0] MAXLEN_RST  = 13'd4096;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MAGIC   = 2'd0;
  localparam logic [1:0] REG_VERSION = 2'd1;
  localparam logic [1:0] REG_RESP    = 2'd2;
  localparam logic [1:0] REG_MAXLEN  = 2'd3;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [31:0]         magic;
    logic [15:0]         version;
    logic [15:0]         command;
    logic [MAXLEN_W-1:0] max_length;
  } cfg_t;

endpackage

// ===== rtl/lfp_parse.sv =====
// ----------------------------------------------------------------------------
// lfp_parse
// Header/payload state and per-byte result decode of the frame parser.
// ----------------------------------------------------------------------------
module lfp_parse #(
  parameter int MAX_PAYLOAD = lfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  lfp_pkg::item_t item,
  input  lfp_pkg::cfg_t  cfg,
  output logic          res_valid,
  output lfp_pkg::res_t  res
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int LIM_W = (LEN_W > lfp_pkg::MAXLEN_W) ? LEN_W : lfp_pkg::MAXLEN_W;
  localparam logic [LIM_W-1:0] CAP        = LIM_W'(MAX_PAYLOAD);
  localparam logic [3:0]       HDR_LAST   = 4'(lfp_pkg::HDR_BYTES - 1);
  localparam logic [3:0]       FRONT_BYTES = 4'(lfp_pkg::HDR_FRONT_BYTES);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HALTED  = 2'd2
  } phase_t;

  phase_t           phase;
  logic [3:0]       hdr_count;
  logic [63:0]      hdr_front;
  logic [31:0]      len_word;
  logic [LEN_W-1:0] bytes_left;

  logic [31:0]      len_full;
  logic [LIM_W-1:0] ml_ext;
  logic [LIM_W-1:0] limit;
  logic             hdr_done;
  logic             hdr_bad;
  logic             pay_last;

  always_comb begin
    len_full = {len_word[23:0], item.rx_byte};
    ml_ext   = LIM_W'(cfg.max_length);
    limit    = (ml_ext > CAP) ? CAP : ml_ext;
    hdr_done = (phase == PH_HEADER) && (hdr_count == HDR_LAST);
    hdr_bad  = (hdr_front[63:32] != cfg.magic) ||
               (hdr_front[31:16] != cfg.version) ||
               (hdr_front[15:0] != cfg.command) ||
               (len_full > 32'(limit));
    pay_last = (bytes_left <= LEN_W'(1));

    res_valid = 1'b0;
    res.kind  = lfp_pkg::KIND_BYTE;
    res.data  = 8'd0;
    res.last  = 1'b0;
    if (!item.restart) begin
      case (phase)
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          res.data  = item.rx_byte;
          res.last  = pay_last;
        end
        PH_HEADER: begin
          if (hdr_done) begin
            res.last = 1'b1;
            if (hdr_bad) begin
              res_valid = 1'b1;
              res.kind  = lfp_pkg::KIND_ERROR;
            end else if (len_full == 32'd0) begin
              res_valid = 1'b1;
              res.kind  = lfp_pkg::KIND_EMPTY;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      hdr_count  <= 4'd0;
      bytes_left <= '0;
    end else if (take) begin
      if (item.restart) begin
        phase      <= PH_HEADER;
        hdr_count  <= 4'd0;
        bytes_left <= '0;
      end else begin
        case (phase)
          PH_HEADER: begin
            if (hdr_done) begin
              hdr_count <= 4'd0;
              if (hdr_bad) begin
                phase <= PH_HALTED;
              end else if (len_full != 32'd0) begin
                // length already bounded by limit, so it fits
                bytes_left <= len_full[LEN_W-1:0];
                phase      <= PH_PAYLOAD;
              end
            end else begin
              hdr_count <= hdr_count + 4'd1;
            end
          end
          PH_PAYLOAD: begin
            if (bytes_left != '0) begin
              bytes_left <= bytes_left - LEN_W'(1);
            end
            if (pay_last) begin
              phase <= PH_HEADER;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // header shift registers; fully refilled before every check
  always_ff @(posedge clk) begin
    if (take && !item.restart && (phase == PH_HEADER)) begin
      if (hdr_count < FRONT_BYTES) begin
        hdr_front <= {hdr_front[55:0], item.rx_byte};
      end else begin
        len_word <= len_full;
      end
    end
  end

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_left != '0))
    else $error("payload phase with no bytes left");

  a_hdr_count_range: assert property (@(posedge clk) disable iff (rst)
    hdr_count <= HDR_LAST)
    else $error("header count past last header byte");

  a_hdr_count_idle: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_HEADER) |-> (hdr_count == 4'd0))
    else $error("header count left over outside header phase");

endmodule

// ===== rtl/lfp_skid.sv =====
// ----------------------------------------------------------------------------
// lfp_skid
// Two-entry result buffer: output register plus one skid entry.
// ----------------------------------------------------------------------------
module lfp_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lfp_pkg::res_t  push_data,
  output logic          space,
  output logic          res_valid,
  input  logic          res_ready,
  output lfp_pkg::res_t  res
);

  logic          skid_valid;
  lfp_pkg::res_t skid_data;
  logic          main_free;

  assign main_free = !res_valid || res_ready;
  assign space     = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (main_free) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid) begin
        res <= skid_data;
      end else if (push) begin
        res <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("beat pushed into full result buffer");

  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> res_valid)
    else $error("skid entry held while output register empty");

endmodule

// ===== rtl/length_prefixed_frame_parser_top.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_top
// Splits a received byte stream into length-prefixed response frames.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_ready/item): one received byte per beat, or a
// restart beat that clears the parser and drops its byte.
// Output channel (res_valid/res_ready/res): payload bytes with last on the
// final one, one empty-frame beat for a zero-length frame, or one error beat
// when a header fails its check; after an error all bytes are dropped until a
// restart beat.
// APB port: magic, version, response command and length limit registers, to be
// written by the user only while the stream is quiet; not enforced in the block.
// A result is registered when the byte that causes it is taken. Throughput:
// one byte per clock while item_ready is high; the header check is one 32-bit
// compare and three equality tests in the same cycle as the byte.
// Stall: item_ready stays high while res_ready is low until a second result
// beat has to wait behind the held one; that beat goes to the skid entry and
// item_ready drops until the output register is accepted and frees the skid.
// Reset: registers return to their defaults, the parser waits for a header,
// the result buffer is empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_top #(
  parameter int MAX_PAYLOAD = lfp_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  lfp_pkg::item_t              item,
  output logic                       res_valid,
  input  logic                       res_ready,
  output lfp_pkg::res_t               res,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lfp_pkg::ADDR_W-1:0] paddr,
  input  logic [lfp_pkg::DATA_W-1:0] pwdata,
  output logic [lfp_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  lfp_pkg::cfg_t cfg;
  lfp_pkg::res_t dec_res;
  logic          dec_valid;
  logic          take;
  logic          wr_en;
  logic [1:0]    reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[3:2];
  assign take    = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic      <= lfp_pkg::MAGIC_RST;
      cfg.version    <= lfp_pkg::VERSION_RST;
      cfg.command    <= lfp_pkg::RESP_RST;
      cfg.max_length <= lfp_pkg::MAXLEN_RST;
    end else if (wr_en) begin
      case (reg_idx)
        lfp_pkg::REG_MAGIC:   cfg.magic      <= pwdata;
        lfp_pkg::REG_VERSION: cfg.version    <= pwdata[15:0];
        lfp_pkg::REG_RESP:    cfg.command    <= pwdata[15:0];
        lfp_pkg::REG_MAXLEN:  cfg.max_length <= pwdata[lfp_pkg::MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      lfp_pkg::REG_MAGIC:   prdata = cfg.magic;
      lfp_pkg::REG_VERSION: prdata = lfp_pkg::DATA_W'(cfg.version);
      lfp_pkg::REG_RESP:    prdata = lfp_pkg::DATA_W'(cfg.command);
      lfp_pkg::REG_MAXLEN:  prdata = lfp_pkg::DATA_W'(cfg.max_length);
      default:              prdata = '0;
    endcase
  end

  lfp_parse #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (item),
    .cfg       (cfg),
    .res_valid (dec_valid),
    .res       (dec_res)
  );

  lfp_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (take && dec_valid),
    .push_data (dec_res),
    .space     (item_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule
